FILE: hdl/nn_scl_pkg.sv
// ----------------------------------------------------------------------------
// nn_scl_pkg
// shared widths, defaults and the configuration struct of the image scaler
// ----------------------------------------------------------------------------
package nn_scl_pkg;

    localparam int CRD_W     = 9;              // coordinate field width
    localparam int SZ_W      = 10;             // size register width
    localparam int PIX_W     = 16;             // rgb565 pixel
    localparam int BYTE_W    = 8;
    localparam int PROD_W    = CRD_W + SZ_W;   // coordinate times size

    localparam int DEF_SIZE  = 360;
    localparam int DST_LIMIT = 512;
    localparam int DEF_MAX_W = 512;
    localparam int DEF_MAX_H = 512;

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // register index, byte address is four times this
    typedef enum logic [2:0] {
        REG_SRC_W = 3'd0,
        REG_SRC_H = 3'd1,
        REG_DST_W = 3'd2,
        REG_DST_H = 3'd3,
        REG_SWAP  = 3'd4
    } t_reg_idx;

    // effective (already clamped) sizes and output mode
    typedef struct packed {
        logic [SZ_W-1:0] src_w;
        logic [SZ_W-1:0] src_h;
        logic [SZ_W-1:0] dst_w;
        logic [SZ_W-1:0] dst_h;
        logic            swap;
    } t_cfg;

endpackage

FILE: hdl/nn_scl_req_if.sv
// ----------------------------------------------------------------------------
// nn_scl_req_if
// request channel: pixel write or destination pixel read
// ----------------------------------------------------------------------------
interface nn_scl_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [nn_scl_pkg::CRD_W-1:0] coord_x;
    logic [nn_scl_pkg::CRD_W-1:0] coord_y;
    logic [nn_scl_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, action, coord_x, coord_y, pixel_in, input ready);
    modport sink   (input valid, action, coord_x, coord_y, pixel_in, output ready);
endinterface

FILE: hdl/nn_scl_res_if.sv
// ----------------------------------------------------------------------------
// nn_scl_res_if
// result channel: one beat per read request
// ----------------------------------------------------------------------------
interface nn_scl_res_if;
    logic                         valid;
    logic                         ready;
    logic [nn_scl_pkg::PIX_W-1:0] pixel_out;
    logic                         coord_error;

    modport source (output valid, pixel_out, coord_error, input ready);
    modport sink   (input valid, pixel_out, coord_error, output ready);
endinterface

FILE: hdl/nn_scl_store.sv
// ----------------------------------------------------------------------------
// nn_scl_store
// source frame store, one write port and one registered read port
// ----------------------------------------------------------------------------
module nn_scl_store #(
    parameter int DEPTH = nn_scl_pkg::DEF_MAX_W * nn_scl_pkg::DEF_MAX_H
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [nn_scl_pkg::PIX_W-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [nn_scl_pkg::PIX_W-1:0] o_rdata
);

    logic [nn_scl_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [nn_scl_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/nn_scl_div.sv
// ----------------------------------------------------------------------------
// nn_scl_div
// two-lane restoring divider, one quotient bit per lane per cycle
// ----------------------------------------------------------------------------
module nn_scl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nn_scl_pkg::PROD_W-1:0] i_dvd_x,
    input  logic [nn_scl_pkg::PROD_W-1:0] i_dvd_y,
    input  logic [nn_scl_pkg::SZ_W-1:0]   i_dvs_x,
    input  logic [nn_scl_pkg::SZ_W-1:0]   i_dvs_y,
    output logic                          o_busy,
    output logic [nn_scl_pkg::SZ_W-1:0]   o_q_x,
    output logic [nn_scl_pkg::SZ_W-1:0]   o_q_y
);

    localparam int QW = nn_scl_pkg::SZ_W;
    localparam int CW = $clog2(QW + 1);

    // quotient is below the source size, so it fits in QW bits and the
    // top dividend bits seed the remainder directly
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_rem_x, r_rem_y, r_lo_x, r_lo_y;
    logic [QW-1:0] r_dvs_x, r_dvs_y;
    logic [QW-1:0] n_rem_x, n_rem_y;
    logic          n_bit_x, n_bit_y;

    function automatic logic [QW:0] div_step(input logic [QW-1:0] rem,
                                             input logic          din,
                                             input logic [QW-1:0] dvs);
        logic [QW:0] t;
        t = {rem, din};
        if (t >= {1'b0, dvs}) begin
            div_step = {QW'(t - {1'b0, dvs}), 1'b1};
        end else begin
            div_step = {t[QW-1:0], 1'b0};
        end
    endfunction

    always_comb begin
        {n_rem_x, n_bit_x} = div_step(r_rem_x, r_lo_x[QW-1], r_dvs_x);
        {n_rem_y, n_bit_y} = div_step(r_rem_y, r_lo_y[QW-1], r_dvs_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem_x <= QW'(i_dvd_x[nn_scl_pkg::PROD_W-1:QW]);
            r_rem_y <= QW'(i_dvd_y[nn_scl_pkg::PROD_W-1:QW]);
            r_lo_x  <= i_dvd_x[QW-1:0];
            r_lo_y  <= i_dvd_y[QW-1:0];
            r_dvs_x <= i_dvs_x;
            r_dvs_y <= i_dvs_y;
        end else if (r_cnt != '0) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_lo_x  <= {r_lo_x[QW-2:0], n_bit_x};
            r_lo_y  <= {r_lo_y[QW-2:0], n_bit_y};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_q_x  = r_lo_x;
    assign o_q_y  = r_lo_y;

endmodule

FILE: hdl/nn_scl_regs.sv
// ----------------------------------------------------------------------------
// nn_scl_regs
// apb register file with clamping of the size registers
// ----------------------------------------------------------------------------
module nn_scl_regs #(
    parameter int MAX_SRC_WIDTH  = nn_scl_pkg::DEF_MAX_W,
    parameter int MAX_SRC_HEIGHT = nn_scl_pkg::DEF_MAX_H
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nn_scl_pkg::APB_AW-1:0] paddr,
    input  logic [nn_scl_pkg::APB_DW-1:0] pwdata,
    output logic [nn_scl_pkg::APB_DW-1:0] prdata,
    output logic                          pready,
    output nn_scl_pkg::t_cfg              o_cfg
);

    localparam int SW = nn_scl_pkg::SZ_W;
    localparam int DW = nn_scl_pkg::APB_DW;

    logic [SW-1:0]        r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic                 r_swap;
    logic                 w_wr;
    nn_scl_pkg::t_reg_idx w_idx;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v, input int hi);
        if (v == '0) begin
            clamp_size = SW'(1);
        end else if (int'(v) > hi) begin
            clamp_size = SW'(hi);
        end else begin
            clamp_size = v;
        end
    endfunction

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = nn_scl_pkg::t_reg_idx'(paddr[nn_scl_pkg::APB_AW-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SW'(nn_scl_pkg::DEF_SIZE);
            r_src_h <= SW'(nn_scl_pkg::DEF_SIZE);
            r_dst_w <= SW'(nn_scl_pkg::DEF_SIZE);
            r_dst_h <= SW'(nn_scl_pkg::DEF_SIZE);
            r_swap  <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                nn_scl_pkg::REG_SRC_W: r_src_w <= pwdata[SW-1:0];
                nn_scl_pkg::REG_SRC_H: r_src_h <= pwdata[SW-1:0];
                nn_scl_pkg::REG_DST_W: r_dst_w <= pwdata[SW-1:0];
                nn_scl_pkg::REG_DST_H: r_dst_h <= pwdata[SW-1:0];
                nn_scl_pkg::REG_SWAP:  r_swap  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            nn_scl_pkg::REG_SRC_W: prdata = DW'(r_src_w);
            nn_scl_pkg::REG_SRC_H: prdata = DW'(r_src_h);
            nn_scl_pkg::REG_DST_W: prdata = DW'(r_dst_w);
            nn_scl_pkg::REG_DST_H: prdata = DW'(r_dst_h);
            nn_scl_pkg::REG_SWAP:  prdata = DW'(r_swap);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.src_w = clamp_size(r_src_w, MAX_SRC_WIDTH);
    assign o_cfg.src_h = clamp_size(r_src_h, MAX_SRC_HEIGHT);
    assign o_cfg.dst_w = clamp_size(r_dst_w, nn_scl_pkg::DST_LIMIT);
    assign o_cfg.dst_h = clamp_size(r_dst_h, nn_scl_pkg::DST_LIMIT);
    assign o_cfg.swap  = r_swap;

endmodule

FILE: hdl/nearest_neighbor_image_scaler_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_unit
// Nearest-neighbour rgb565 scaler over a source frame store. A write request
// stores one pixel: it is accepted in S_IDLE and written to memory in S_WR; a
// write outside the source size is dropped. A read request passes from accept
// through S_MUL for the coordinate products, S_DIV for the two-lane divider
// (ten quotient steps, then the finish is seen) that finds the source column
// and row, S_ADDR for the address, S_RD for the frame memory read and S_RESP
// to load the output register, which waits while an earlier beat is still
// held at the output. A read outside the destination size goes straight to
// S_RESP and gives a beat of zero with the error flag set. The frame
// store has no reset and needs no clearing pass; a pixel must be written
// before it is read. The next request is taken while a result beat still
// waits at the output.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_unit #(
    parameter int MAX_SRC_WIDTH  = nn_scl_pkg::DEF_MAX_W,
    parameter int MAX_SRC_HEIGHT = nn_scl_pkg::DEF_MAX_H
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nn_scl_req_if.sink                    i_req,
    nn_scl_res_if.source                  o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nn_scl_pkg::APB_AW-1:0] paddr,
    input  logic [nn_scl_pkg::APB_DW-1:0] pwdata,
    output logic [nn_scl_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = nn_scl_pkg::CRD_W;
    localparam int SW    = nn_scl_pkg::SZ_W;
    localparam int PW    = nn_scl_pkg::PIX_W;
    localparam int MW    = nn_scl_pkg::PROD_W;
    localparam int BW    = nn_scl_pkg::BYTE_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WR   = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_ADDR = 7'b0010000,
        S_RD   = 7'b0100000,
        S_RESP = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    nn_scl_pkg::t_cfg w_cfg;

    logic [CW-1:0] r_x, r_y;
    logic [PW-1:0] r_pix;
    logic          r_err;
    logic [AW-1:0] r_addr;

    logic          r_ov;
    logic [PW-1:0] r_opix;
    logic          r_oerr;

    logic          w_acc, w_wr_ok, w_rd_bad, w_out_load;
    logic          w_we, w_re, w_div_busy;
    logic [AW-1:0] w_waddr;
    logic [PW-1:0] w_rdata, w_pix_sel;
    logic [SW-1:0] w_qx, w_qy, w_sx, w_sy;
    logic [MW-1:0] w_dvd_x, w_dvd_y;

    nn_scl_regs #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_dvd_x = MW'(r_x) * MW'(w_cfg.src_w);
    assign w_dvd_y = MW'(r_y) * MW'(w_cfg.src_h);

    nn_scl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_dvd_x (w_dvd_x),
        .i_dvd_y (w_dvd_y),
        .i_dvs_x (w_cfg.dst_w),
        .i_dvs_y (w_cfg.dst_h),
        .o_busy  (w_div_busy),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy)
    );

    assign w_we    = (r_state == S_WR);
    assign w_re    = (r_state == S_RD);
    assign w_waddr = AW'(int'(r_y) * MAX_SRC_WIDTH) + AW'(r_x);

    nn_scl_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_pix),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // request decode at the accepting edge
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid & i_req.ready;
    assign w_wr_ok     = ({1'b0, i_req.coord_x} < w_cfg.src_w) &&
                         ({1'b0, i_req.coord_y} < w_cfg.src_h);
    assign w_rd_bad    = ({1'b0, i_req.coord_x} >= w_cfg.dst_w) ||
                         ({1'b0, i_req.coord_y} >= w_cfg.dst_h);
    assign w_out_load  = (r_state == S_RESP) && (!r_ov || o_res.ready);

    // last column or row when the quotient overshoots
    assign w_sx = (w_qx >= w_cfg.src_w) ? w_cfg.src_w - 1'b1 : w_qx;
    assign w_sy = (w_qy >= w_cfg.src_h) ? w_cfg.src_h - 1'b1 : w_qy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req.action == nn_scl_pkg::ACT_WRITE) begin
                        n_state = w_wr_ok ? S_WR : S_IDLE;
                    end else begin
                        n_state = w_rd_bad ? S_RESP : S_MUL;
                    end
                end
            end
            S_WR:   n_state = S_IDLE;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (!w_div_busy) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_RD;
            S_RD:   n_state = S_RESP;
            S_RESP: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x   <= i_req.coord_x;
            r_y   <= i_req.coord_y;
            r_pix <= i_req.pixel_in;
            r_err <= w_rd_bad;
        end
        if (r_state == S_ADDR) begin
            r_addr <= AW'(int'(w_sy) * MAX_SRC_WIDTH) + AW'(w_sx);
        end
    end

    assign w_pix_sel = w_cfg.swap ? {w_rdata[BW-1:0], w_rdata[PW-1:BW]} : w_rdata;

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_opix <= r_err ? '0 : w_pix_sel;
            r_oerr <= r_err;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.pixel_out   = r_opix;
    assign o_res.coord_error = r_oerr;

    a_div_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> w_div_busy)
        else $error("divider not busy after start");

    a_mem_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("frame store written and read together");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_err) |=> (o_res.pixel_out == '0 && o_res.coord_error))
        else $error("error beat carries a pixel");

    a_write_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.action == nn_scl_pkg::ACT_WRITE) |=> !w_out_load)
        else $error("write request produced a result");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbour image scaler. Pixel writes and
// destination reads go in on the request channel. A scoreboard keeps its own
// copy of the frame store and of the sizes, works out each scaled pixel and
// compares it with every result beat. Size and swap settings are changed over
// the apb port between phases. Both channels idle at random, and the result
// side is held off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CRD_W     = nn_scl_pkg::CRD_W;
    localparam int SZ_W      = nn_scl_pkg::SZ_W;
    localparam int PIX_W     = nn_scl_pkg::PIX_W;
    localparam int BYTE_W    = nn_scl_pkg::BYTE_W;
    localparam int APB_AW    = nn_scl_pkg::APB_AW;
    localparam int APB_DW    = nn_scl_pkg::APB_DW;
    localparam int DEF_SIZE  = nn_scl_pkg::DEF_SIZE;
    localparam int DST_LIMIT = nn_scl_pkg::DST_LIMIT;
    localparam int MAX_W     = nn_scl_pkg::DEF_MAX_W;
    localparam int MAX_H     = nn_scl_pkg::DEF_MAX_H;

    localparam int STORE_DEPTH = MAX_W * MAX_H;
    localparam int DRAIN_WAIT  = 20;      // longer than the read pipeline
    localparam int HOLD_OFF    = 400;
    localparam int PHASE_ITEMS = 190;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             coord_error;
    } t_scaled_pixel;

    class scaled_pixel_scoreboard;
        nn_scl_pkg::t_cfg cfg;
        logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
        bit               written [STORE_DEPTH];
        t_scaled_pixel    awaited [$];
        int               errors;

        function new();
            cfg    = '{src_w: SZ_W'(DEF_SIZE), src_h: SZ_W'(DEF_SIZE),
                       dst_w: SZ_W'(DEF_SIZE), dst_h: SZ_W'(DEF_SIZE), swap: 1'b1};
            errors = 0;
        endfunction

        static function logic [SZ_W-1:0] clamp_size(int unsigned v, int unsigned hi);
            if (v == 0) return SZ_W'(1);
            if (v > hi) return SZ_W'(hi);
            return SZ_W'(v);
        endfunction

        function void write_register(nn_scl_pkg::t_reg_idx idx, logic [APB_DW-1:0] value);
            logic [SZ_W-1:0] v10;
            v10 = value[SZ_W-1:0];
            case (idx)
                nn_scl_pkg::REG_SRC_W: cfg.src_w = clamp_size(v10, MAX_W);
                nn_scl_pkg::REG_SRC_H: cfg.src_h = clamp_size(v10, MAX_H);
                nn_scl_pkg::REG_DST_W: cfg.dst_w = clamp_size(v10, DST_LIMIT);
                nn_scl_pkg::REG_DST_H: cfg.dst_h = clamp_size(v10, DST_LIMIT);
                nn_scl_pkg::REG_SWAP:  cfg.swap  = value[0];
                default: ;
            endcase
        endfunction

        // destination coordinate to source pixel; 0 when outside the destination
        function bit to_source(int x, int y, output int sx, output int sy);
            sx = 0;
            sy = 0;
            if (x >= int'(cfg.dst_w) || y >= int'(cfg.dst_h)) return 1'b0;
            sx = x * int'(cfg.src_w) / int'(cfg.dst_w);
            if (sx >= int'(cfg.src_w)) sx = int'(cfg.src_w) - 1;
            sy = y * int'(cfg.src_h) / int'(cfg.dst_h);
            if (sy >= int'(cfg.src_h)) sy = int'(cfg.src_h) - 1;
            return 1'b1;
        endfunction

        function bit needs_fill(int x, int y);
            int sx, sy;
            if (!to_source(x, y, sx, sy)) return 1'b0;
            return !written[sy * MAX_W + sx];
        endfunction

        function void take_request(logic act, int x, int y, logic [PIX_W-1:0] pix);
            t_scaled_pixel    res;
            int               sx, sy;
            logic [PIX_W-1:0] px;
            if (act == nn_scl_pkg::ACT_WRITE) begin
                if (x < int'(cfg.src_w) && y < int'(cfg.src_h)) begin
                    frame_copy[y * MAX_W + x] = pix;
                    written[y * MAX_W + x]    = 1'b1;
                end
                return;
            end
            if (!to_source(x, y, sx, sy)) begin
                res.pixel       = '0;
                res.coord_error = 1'b1;
            end else begin
                px              = frame_copy[sy * MAX_W + sx];
                res.pixel       = cfg.swap ? {px[BYTE_W-1:0], px[PIX_W-1:BYTE_W]} : px;
                res.coord_error = 1'b0;
            end
            awaited.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("ERROR: %s", msg);
        endtask

        task check_pixel(logic [PIX_W-1:0] pix, logic err);
            t_scaled_pixel want;
            if (awaited.size() == 0) begin
                report($sformatf("beat with nothing awaited: pixel %h error %b", pix, err));
                return;
            end
            want = awaited.pop_front();
            if (pix !== want.pixel)
                report($sformatf("pixel_out %h, expected %h", pix, want.pixel));
            if (err !== want.coord_error)
                report($sformatf("coord_error %b, expected %b", err, want.coord_error));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    nn_scl_req_if req_if ();
    nn_scl_res_if res_if ();

    scaled_pixel_scoreboard sb;

    bit quiet;          // no random idling on either side while set (the result hold-off still counts down)
    int rx_wait;
    int hold_cnt;

    nearest_neighbor_image_scaler_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("ERROR: run timed out");
        $display("Verification failed");
        $finish;
    end

    // result side: ready is decided at the falling edge
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                res_if.ready <= 1'b0;
                hold_cnt--;
            end else if (rx_wait > 0) begin
                res_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_pixel(res_if.pixel_out, res_if.coord_error);
            rx_wait = quiet ? 0 : $urandom_range(0, 13);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(logic act, int x, int y, int pix);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.action   <= act;
        req_if.coord_x  <= CRD_W'(x);
        req_if.coord_y  <= CRD_W'(y);
        req_if.pixel_in <= PIX_W'(pix);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.take_request(act, x, y, PIX_W'(pix));
        @(negedge i_clk);
    endtask

    // a read never lands on an unwritten source pixel: write it first
    task automatic read_pixel(int x, int y);
        int sx, sy;
        if (sb.needs_fill(x, y)) begin
            void'(sb.to_source(x, y, sx, sy));
            send_item(nn_scl_pkg::ACT_WRITE, sx, sy, $urandom_range(0, 16'hFFFF));
        end
        send_item(nn_scl_pkg::ACT_READ, x, y, $urandom_range(0, 16'hFFFF));
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic apb_write(nn_scl_pkg::t_reg_idx idx, logic [APB_DW-1:0] value);
        logic [APB_AW-1:0] addr;
        addr = APB_AW'(int'(idx) * 4);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic configure(int sw, int sh, int dw, int dh, int swap);
        drain();
        apb_write(nn_scl_pkg::REG_SRC_W, sw);
        apb_write(nn_scl_pkg::REG_SRC_H, sh);
        apb_write(nn_scl_pkg::REG_DST_W, dw);
        apb_write(nn_scl_pkg::REG_DST_H, dh);
        apb_write(nn_scl_pkg::REG_SWAP, swap);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // default sizes 360x360 with swap on
    task automatic directed_items();
        send_item(nn_scl_pkg::ACT_WRITE, 0, 0, 16'hFFFF);
        send_item(nn_scl_pkg::ACT_WRITE, 359, 359, 16'h0000);
        send_item(nn_scl_pkg::ACT_WRITE, 1, 0, 16'h1234);
        send_item(nn_scl_pkg::ACT_WRITE, 200, 100, 16'h00FF);
        send_item(nn_scl_pkg::ACT_WRITE, 100, 200, 16'hFF00);
        // writes outside the source are dropped
        send_item(nn_scl_pkg::ACT_WRITE, 511, 511, 16'hA5A5);
        send_item(nn_scl_pkg::ACT_WRITE, 360, 0, 16'h5A5A);
        send_item(nn_scl_pkg::ACT_WRITE, 0, 360, 16'hC3C3);
        read_pixel(0, 0);
        read_pixel(359, 359);
        read_pixel(1, 0);
        read_pixel(200, 100);
        read_pixel(100, 200);
        // reads outside the destination
        read_pixel(360, 0);
        read_pixel(0, 360);
        read_pixel(511, 511);
        read_pixel(511, 0);
        read_pixel(0, 511);
    endtask

    task automatic random_items(int count, bit hold);
        int n, x, y;
        n = 0;
        if (hold) begin
            @(posedge i_clk);
            hold_cnt = HOLD_OFF;
            @(negedge i_clk);
        end
        while (n < count) begin
            if (n % 60 == 0) quiet = (hold && n == 0) || ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 4) begin
                if ($urandom_range(0, 6) == 0) begin
                    x = $urandom_range(0, 511);
                    y = $urandom_range(0, 511);
                end else begin
                    x = $urandom_range(0, int'(sb.cfg.src_w) - 1);
                    y = $urandom_range(0, int'(sb.cfg.src_h) - 1);
                end
                send_item(nn_scl_pkg::ACT_WRITE, x, y, $urandom_range(0, 16'hFFFF));
            end else begin
                if ($urandom_range(0, 6) == 0) begin
                    x = $urandom_range(0, 511);
                    y = $urandom_range(0, 511);
                end else begin
                    x = $urandom_range(0, int'(sb.cfg.dst_w) - 1);
                    y = $urandom_range(0, int'(sb.cfg.dst_h) - 1);
                end
                read_pixel(x, y);
            end
            n++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        sb               = new();
        quiet            = 1'b0;
        rx_wait          = 0;
        hold_cnt         = 0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.action    = nn_scl_pkg::ACT_WRITE;
        req_if.coord_x   = '0;
        req_if.coord_y   = '0;
        req_if.pixel_in  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_items();
        random_items(PHASE_ITEMS, 1'b0);

        configure(8, 8, 16, 16, 0);          // upscale
        random_items(PHASE_ITEMS, 1'b1);
        configure(16, 12, 5, 7, 1);          // downscale
        random_items(PHASE_ITEMS, 1'b0);
        configure(512, 512, 512, 512, 0);
        random_items(PHASE_ITEMS, 1'b0);
        configure(1, 1, 1, 1, 1);
        random_items(PHASE_ITEMS, 1'b0);
        configure(0, 0, 0, 0, 0);            // zero sizes act as one
        random_items(PHASE_ITEMS, 1'b1);
        configure(1023, 700, 1023, 513, 1);  // oversize settings saturate
        random_items(PHASE_ITEMS, 1'b0);
        configure(3, 500, 500, 3, 0);
        random_items(PHASE_ITEMS / 2, 1'b0);
        configure($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
                  $urandom_range(1, 40), $urandom_range(0, 1));
        random_items(PHASE_ITEMS / 2, 1'b0);

        drain();
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/nn_scl_pkg.sv
hdl/nn_scl_req_if.sv
hdl/nn_scl_res_if.sv
hdl/nn_scl_store.sv
hdl/nn_scl_div.sv
hdl/nn_scl_regs.sv
hdl/nearest_neighbor_image_scaler_unit.sv
dv/testbench.sv
